@@ src/mpid_pkg.sv @@
`timescale 1ns / 1ps
// mpid_pkg.sv: shared constants, beat types and controller/datapath command structs
// for the multichannel pid controller; no dependencies
package mpid_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // sum of the three terms keeps 48 fraction bits and stays below 2^97 in magnitude
  localparam int ACC_W    = 100;
  localparam int ACC_FRAC = 48;
  localparam int QW       = ACC_W - ACC_FRAC;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ED_W     = 50;

  localparam logic [31:0] SAMPLE_PERIOD_RST   = 32'd4294967;
  localparam logic [15:0] DERIVATIVE_RATE_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_RATE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_GAINS  = 2'd1,
    OP_ENABLE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         channel;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic               enable;
  } item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               enabled;
    logic               saturated;
  } result_t;

  typedef enum logic [2:0] {
    MUL_PER,
    MUL_RATE,
    MUL_KP,
    MUL_KIL,
    MUL_KIH,
    MUL_KDL,
    MUL_KDH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_SH0,
    ACC_SH16,
    ACC_SH32,
    ACC_SH48
  } acc_op_t;

  typedef struct packed {
    logic     load;
    logic     err_en;
    logic     int_en;
    logic     ed_en;
    logic     neg_en;
    logic     rnd_en;
    logic     fin;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } pid_cmd_t;

  typedef struct packed {
    logic step_run;
  } pid_sts_t;

endpackage

@@ src/mpid_ctrl.sv @@
`timescale 1ns / 1ps
// mpid_ctrl.sv: sequencer for the pid controller, one item at a time
// depends on mpid_pkg
module mpid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  mpid_pkg::pid_sts_t sts,
  output mpid_pkg::pid_cmd_t cmd
);
  import mpid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MPER,
    S_MRATE,
    S_MKP,
    S_MKIL,
    S_MKIH,
    S_MKDL,
    S_MKDH,
    S_ACC,
    S_NEG,
    S_RND,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   out_free;

  assign item_stall = rst | (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_next = sts.step_run ? S_MPER : S_FIN;
      end
      S_MPER: begin
        cmd.mul_sel = MUL_PER;
        state_next  = S_MRATE;
      end
      S_MRATE: begin
        cmd.int_en  = 1'b1;
        cmd.mul_sel = MUL_RATE;
        state_next  = S_MKP;
      end
      S_MKP: begin
        cmd.ed_en   = 1'b1;
        cmd.mul_sel = MUL_KP;
        cmd.acc_op  = ACC_CLR;
        state_next  = S_MKIL;
      end
      S_MKIL: begin
        cmd.mul_sel = MUL_KIL;
        cmd.acc_op  = ACC_SH16;
        state_next  = S_MKIH;
      end
      S_MKIH: begin
        cmd.mul_sel = MUL_KIH;
        cmd.acc_op  = ACC_SH0;
        state_next  = S_MKDL;
      end
      S_MKDL: begin
        cmd.mul_sel = MUL_KDL;
        cmd.acc_op  = ACC_SH32;
        state_next  = S_MKDH;
      end
      S_MKDH: begin
        cmd.mul_sel = MUL_KDH;
        cmd.acc_op  = ACC_SH16;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_op = ACC_SH48;
        state_next = S_NEG;
      end
      S_NEG: begin
        cmd.neg_en = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.fin) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

@@ src/mpid_datapath.sv @@
`timescale 1ns / 1ps
// mpid_datapath.sv: channel state, config registers, shared 33x33 multiplier,
// wide accumulator and rounding; depends on mpid_pkg
module mpid_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpid_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  mpid_pkg::item_t                     item,
  input  mpid_pkg::pid_cmd_t                  cmd,
  output mpid_pkg::pid_sts_t                  sts,
  output mpid_pkg::result_t                   result
);
  import mpid_pkg::*;

  logic [31:0] sample_period;
  logic [15:0] derivative_rate;

  logic signed [63:0] integral_store   [CHANNELS];
  logic signed [31:0] last_error_store [CHANNELS];
  logic signed [31:0] prop_gain_store  [CHANNELS];
  logic signed [31:0] int_gain_store   [CHANNELS];
  logic signed [31:0] deriv_gain_store [CHANNELS];
  logic [CHANNELS-1:0] enable_flags;

  item_t               cur;
  logic [CH_W-1:0]     idx;
  logic                chan_ok;
  logic signed [63:0]  int_cur;
  logic signed [31:0]  last_cur;
  logic signed [31:0]  kp_cur;
  logic signed [31:0]  ki_cur;
  logic signed [31:0]  kd_cur;
  logic                en_cur;
  logic                en_after;

  logic signed [32:0]  diff;
  logic signed [31:0]  err_sat;
  logic signed [31:0]  err;
  logic signed [32:0]  err_diff;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [64:0] inc_ext;
  logic signed [64:0] isum;
  logic signed [63:0] ei;
  logic               sat_int;
  logic signed [ED_W-1:0] ed;

  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_neg;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        rsum;
  logic [QW-1:0]           qhi;
  logic signed [31:0]      drv;
  logic                    sat_drv;

  // channel lookup
  assign idx      = CH_W'(cur.channel);
  assign chan_ok  = int'(cur.channel) < CHANNELS;
  assign int_cur  = integral_store[idx];
  assign last_cur = last_error_store[idx];
  assign kp_cur   = prop_gain_store[idx];
  assign ki_cur   = int_gain_store[idx];
  assign kd_cur   = deriv_gain_store[idx];
  assign en_cur   = enable_flags[idx];
  assign en_after = (cur.op == OP_ENABLE) ? cur.enable : en_cur;

  assign sts.step_run = chan_ok && (cur.op == OP_STEP) && en_cur;

  // saturated error
  assign diff = {cur.target[31], cur.target} - {cur.measured[31], cur.measured};
  always_comb begin
    if (diff[32] != diff[31]) begin
      err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_sat = diff[31:0];
    end
  end

  assign err_diff = {err[31], err} - {last_cur[31], last_cur};

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_PER: begin
        mul_a = MUL_W'(err);
        mul_b = {1'b0, sample_period};
      end
      MUL_RATE: begin
        mul_a = err_diff;
        mul_b = MUL_W'(derivative_rate);
      end
      MUL_KP: begin
        mul_a = MUL_W'(kp_cur);
        mul_b = MUL_W'(err);
      end
      MUL_KIL: begin
        mul_a = MUL_W'(ki_cur);
        mul_b = {1'b0, ei[31:0]};
      end
      MUL_KIH: begin
        mul_a = MUL_W'(ki_cur);
        mul_b = MUL_W'(signed'(ei[63:32]));
      end
      MUL_KDL: begin
        mul_a = MUL_W'(kd_cur);
        mul_b = {1'b0, ed[31:0]};
      end
      MUL_KDH: begin
        mul_a = MUL_W'(kd_cur);
        mul_b = MUL_W'(signed'(ed[ED_W-1:32]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor of error * period / 2^16, added with saturation to 64 bits
  assign inc_ext = 65'(signed'(prod[PROD_W-1:16]));
  assign isum    = {int_cur[63], int_cur} + inc_ext;

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  always_comb begin
    unique case (cmd.acc_op)
      ACC_SH0:  addend = prod_ext;
      ACC_SH16: addend = prod_ext <<< 16;
      ACC_SH32: addend = prod_ext <<< 32;
      ACC_SH48: addend = prod_ext <<< 48;
      default:  addend = '0;
    endcase
  end

  assign rsum = mag + (ACC_W'(1) << (ACC_FRAC - 1));

  // round half away from zero, then clamp
  always_comb begin
    if (acc_neg) begin
      if (qhi > QW'(32'h8000_0000)) begin
        drv     = 32'sh8000_0000;
        sat_drv = 1'b1;
      end else begin
        drv     = 32'd0 - qhi[31:0];
        sat_drv = 1'b0;
      end
    end else begin
      if (qhi > QW'(32'h7fff_ffff)) begin
        drv     = 32'sh7fff_ffff;
        sat_drv = 1'b1;
      end else begin
        drv     = qhi[31:0];
        sat_drv = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= SAMPLE_PERIOD_RST;
      derivative_rate <= DERIVATIVE_RATE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SAMPLE_PERIOD) begin
        sample_period <= cfg_data[31:0];
      end
      if (cfg_index == REG_DERIVATIVE_RATE) begin
        derivative_rate <= cfg_data[15:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.err_en) begin
      err <= err_sat;
    end
    if (cmd.int_en) begin
      if (isum[64] != isum[63]) begin
        ei      <= isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        sat_int <= 1'b1;
      end else begin
        ei      <= isum[63:0];
        sat_int <= 1'b0;
      end
    end
    if (cmd.ed_en) begin
      ed <= prod[ED_W-1:0];
    end
    if (cmd.acc_op == ACC_CLR) begin
      acc <= '0;
    end else if (cmd.acc_op != ACC_HOLD) begin
      acc <= acc + addend;
    end
    if (cmd.neg_en) begin
      acc_neg <= acc[ACC_W-1];
      mag     <= acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
    end
    if (cmd.rnd_en) begin
      qhi <= rsum[ACC_W-1:ACC_FRAC];
    end
    if (cmd.fin) begin
      result.drive     <= sts.step_run ? drv : 32'sd0;
      result.saturated <= sts.step_run & (sat_int | sat_drv);
      result.enabled   <= chan_ok & en_after;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integral_store[i]   <= '0;
        last_error_store[i] <= '0;
        prop_gain_store[i]  <= '0;
        int_gain_store[i]   <= '0;
        deriv_gain_store[i] <= '0;
      end
      enable_flags <= '0;
    end else if (cmd.fin && chan_ok) begin
      unique case (cur.op)
        OP_STEP: begin
          if (en_cur) begin
            integral_store[idx]   <= ei;
            last_error_store[idx] <= err;
          end else begin
            integral_store[idx]   <= '0;
            last_error_store[idx] <= '0;
          end
        end
        OP_GAINS: begin
          prop_gain_store[idx]  <= cur.gain_p;
          int_gain_store[idx]   <= cur.gain_i;
          deriv_gain_store[idx] <= cur.gain_d;
        end
        OP_ENABLE: begin
          enable_flags[idx] <= cur.enable;
        end
        OP_CLEAR: begin
          integral_store[idx]   <= '0;
          last_error_store[idx] <= '0;
        end
      endcase
    end
  end

endmodule

@@ src/multichannel_pid_controller.sv @@
`timescale 1ns / 1ps
// multichannel_pid_controller.sv: top level of the 16-channel positional pid regulator
// depends on mpid_pkg, mpid_ctrl and mpid_datapath
//
// item channel (item_valid/item_stall/item) carries one operation on one channel:
// control step, gain write, enable write or clear. every item yields exactly one
// result beat (result_valid/result_stall/result) with drive, enabled and saturated.
// a beat moves at a clock edge with valid high and stall low.
// a control step on an enabled channel runs error, the seven products, accumulate,
// negate, round and finish; every other item goes from error straight to finish. the
// next item is taken once the sequencer is back in idle. the step time is set by
// the single shared 33x33 multiplier, which forms seven products one after another.
// a finished result sits in the output register; the block takes the next item while
// it waits, and a stalled result only holds the sequencer at its last state.
// cfg_wr_en/cfg_index/cfg_data write sample_period (index 0) or derivative_rate
// (index 1); write only while the block is idle.
// rst (synchronous) clears all channel state, gains and enable flags, loads the
// register defaults and drops result_valid; item_stall is high during reset.
module multichannel_pid_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpid_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  mpid_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output mpid_pkg::result_t                 result
);
  import mpid_pkg::*;

  pid_cmd_t cmd;
  pid_sts_t sts;

  mpid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mpid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  // one item in flight: a taken beat closes the input for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken while a previous item is in flight");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.fin))
    else $error("result beat raised without a finish command");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.drive == 32'sd0) || result.enabled)
    else $error("nonzero drive from a disabled channel");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.enabled)
    else $error("saturation flagged on a disabled channel");

endmodule

@@ tb/multichannel_pid_controller_test.sv @@
`timescale 1ns / 1ps
// multichannel_pid_controller_test.sv: self-checking bench for the 16-channel pid regulator;
// predicts every result beat in fixed point and compares it field by field
// depends on mpid_pkg and multichannel_pid_controller
module multichannel_pid_controller_test;
  import mpid_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 16;
  localparam int IDLE_PERCENT = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  // channel state and registers as the block should hold them
  logic signed [63:0] integral_q [CHANNELS];
  logic signed [31:0] last_err [CHANNELS];
  logic signed [31:0] kp [CHANNELS];
  logic signed [31:0] ki [CHANNELS];
  logic signed [31:0] kd [CHANNELS];
  logic               chan_on [CHANNELS];
  logic [31:0]        period_cfg;
  logic [15:0]        rate_cfg;

  result_t pending_results [$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  int      holds_asked = 0;
  int      holds_served = 0;
  int      hold_cnt = 0;

  multichannel_pid_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic reset_model();
    period_cfg = SAMPLE_PERIOD_RST;
    rate_cfg   = DERIVATIVE_RATE_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      integral_q[c] = '0;
      last_err[c]   = '0;
      kp[c]         = '0;
      ki[c]         = '0;
      kd[c]         = '0;
      chan_on[c]    = 1'b0;
    end
  endtask

  function automatic result_t predict_pid_result(item_t it);
    result_t             r;
    int                  c;
    logic                sat;
    logic                neg;
    logic signed [63:0]  err;
    logic signed [63:0]  prod;
    logic signed [63:0]  acc;
    logic signed [64:0]  acc_sum;
    logic signed [63:0]  dterm;
    logic signed [127:0] t;
    logic signed [127:0] sum;
    logic signed [127:0] mag;
    logic [127:0]        q;
    r   = '0;
    sat = 1'b0;
    c   = it.channel;
    case (it.op)
      OP_STEP: begin
        if (chan_on[c]) begin
          err = $signed(it.target) - $signed(it.measured);
          if (err > 64'sh7FFF_FFFF) err = 64'sh7FFF_FFFF;
          else if (err < -64'sh8000_0000) err = -64'sh8000_0000;
          prod = err * $signed({32'd0, period_cfg});
          acc_sum = integral_q[c] + (prod >>> 16);
          if (acc_sum[64] != acc_sum[63]) begin
            sat = 1'b1;
            acc = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc = acc_sum[63:0];
          end
          integral_q[c] = acc;
          dterm = (err - last_err[c]) * $signed({48'd0, rate_cfg});
          last_err[c] = err[31:0];
          t = kp[c];
          t = t * err;
          sum = t <<< 16;
          t = ki[c];
          t = t * acc;
          sum = sum + t;
          t = kd[c];
          t = t * dterm;
          sum = sum + (t <<< 16);
          neg = sum < 0;
          mag = neg ? -sum : sum;
          mag = mag + (128'sd1 <<< 47);
          q = mag >> 48;
          if (neg) begin
            if (q > 128'h8000_0000) begin
              q   = 128'h8000_0000;
              sat = 1'b1;
            end
            r.drive = -q[31:0];
          end else begin
            if (q > 128'h7FFF_FFFF) begin
              q   = 128'h7FFF_FFFF;
              sat = 1'b1;
            end
            r.drive = q[31:0];
          end
        end else begin
          integral_q[c] = '0;
          last_err[c]   = '0;
        end
      end
      OP_GAINS: begin
        kp[c] = it.gain_p;
        ki[c] = it.gain_i;
        kd[c] = it.gain_d;
      end
      OP_ENABLE: chan_on[c] = it.enable;
      default: begin
        integral_q[c] = '0;
        last_err[c]   = '0;
      end
    endcase
    r.enabled   = chan_on[c];
    r.saturated = sat;
    return r;
  endfunction

  // receiver: checks every accepted result beat and drives the stall pattern
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, drive %0d", $time, result.drive);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.drive !== want.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, result.drive);
          mismatches++;
        end
        if (result.enabled !== want.enabled) begin
          $display("%0t: enabled expected %0b actual %0b", $time, want.enabled,
                   result.enabled);
          mismatches++;
        end
        if (result.saturated !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                   result.saturated);
          mismatches++;
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_cnt     <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(predict_pid_result(it));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SAMPLE_PERIOD:   period_cfg = data;
      REG_DERIVATIVE_RATE: rate_cfg   = data[15:0];
      default: ;
    endcase
  endtask

  function automatic item_t make_item(op_t op, int ch, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                                      logic en);
    item_t it;
    it.op       = op;
    it.channel  = 4'(ch);
    it.target   = a;
    it.measured = b;
    it.gain_p   = gp;
    it.gain_i   = gi;
    it.gain_d   = gd;
    it.enable   = en;
    return it;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(3))
      0: return w;
      1: return {{12{w[19]}}, w[19:0]};
      2: return {{15{w[16]}}, w[16:0]};
      default: begin
        case (w[1:0])
          2'd0: return 32'h7FFF_FFFF;
          2'd1: return 32'h8000_0000;
          2'd2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: return w;
      1: return {{20{w[11]}}, w[11:0]};
      2, 3: return {{16{w[15]}}, w[15:0]};
      default: return w[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    it = make_item(OP_STEP, $urandom_range(CHANNELS - 1), pick_word(), pick_word(),
                   pick_gain(), pick_gain(), pick_gain(), $urandom_range(99) < 80);
    if (pick >= 90) it.op = OP_CLEAR;
    else if (pick >= 75) it.op = OP_ENABLE;
    else if (pick >= 60) it.op = OP_GAINS;
    return it;
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) send_item(random_item());
  endtask

  task automatic test_directed();
    send_item(make_item(OP_STEP, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1'b0));
    send_item(make_item(OP_GAINS, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        1'b0));
    send_item(make_item(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_STEP, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b0));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 0, 32'h0001_0000, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_STEP, 0, 32'h0002_0000, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ENABLE, 0, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1'b0));
    // half-way cases round away from zero
    send_item(make_item(OP_GAINS, 15, 0, 0, 32'h0000_8000, 0, 0, 1'b0));
    send_item(make_item(OP_ENABLE, 15, 0, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_STEP, 15, 32'h0001_0000, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 15, 32'hFFFF_0000, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 15, 32'h0001_8000, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_GAINS, 15, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0001,
                        1'b0));
    send_item(make_item(OP_STEP, 15, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 1'b0));
    send_item(make_item(OP_GAINS, 15, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_STEP, 15, 32'h1234_5678, 32'h8765_4321, 0, 0, 0, 1'b0));
    send_item(make_item(OP_CLEAR, 15, 0, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ENABLE, 15, 0, 0, 0, 0, 0, 1'b0));
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [31:0] periods [5];
    logic [31:0] rates [5];
    periods = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, $urandom, SAMPLE_PERIOD_RST};
    rates   = '{32'd0, 32'h0000_FFFF, 32'd1, $urandom, DERIVATIVE_RATE_RST};
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_SAMPLE_PERIOD, periods[s]);
      write_reg(REG_DERIVATIVE_RATE, rates[s]);
      send_random(120);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    holds_asked++;
    send_random(40);
    quiet = 1'b0;
    wait_drained();
    send_random(40);
    wait_drained();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    send_random(100);
    quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mpid_pkg.sv
src/mpid_ctrl.sv
src/mpid_datapath.sv
src/multichannel_pid_controller.sv
tb/multichannel_pid_controller_test.sv
